[rtl/core/hbb_pkg.sv]
package hbb_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		RegInitialRank   = 2'd0,
		RegSwapThreshold = 2'd1,
		RegBias          = 2'd2
	} hbb_reg_t;

	localparam int RankW  = 7;
	localparam int FillW  = 7;
	localparam int Log2W  = 12;
	localparam int EstW   = 64;
	localparam int MapW   = 64;
	localparam int FracW  = 16;

	localparam logic [RankW-1:0] RankMax       = 7'd64;
	localparam logic [5:0]       InitRankReset = 6'd5;
	localparam logic [5:0]       ThreshReset   = 6'd31;
	localparam logic [9:0]       BiasReset     = 10'd173;

	// round(2^(f/32) * 2^16) for f = 0..31.
	localparam logic [16:0] PowTable [32] = '{
		17'd65536,  17'd66971,  17'd68438,  17'd69936,
		17'd71468,  17'd73032,  17'd74632,  17'd76266,
		17'd77936,  17'd79642,  17'd81386,  17'd83169,
		17'd84990,  17'd86851,  17'd88752,  17'd90696,
		17'd92682,  17'd94711,  17'd96785,  17'd98905,
		17'd101070, 17'd103283, 17'd105545, 17'd107856,
		17'd110218, 17'd112631, 17'd115098, 17'd117618,
		17'd120194, 17'd122825, 17'd125515, 17'd128263
	};

	// Rank and fill of the sketch after one update.
	typedef struct packed {
		logic [RankW-1:0] rank;
		logic [FillW-1:0] fill;
	} hbb_upd_t;

	// Number of set bits in a 64-bit word.
	function automatic logic [FillW-1:0] popcount64(input logic [MapW-1:0] w);
		logic [FillW-1:0] n;
		n = '0;
		for (int i = 0; i < MapW; i++) begin
			n = n + FillW'(w[i]);
		end
		return n;
	endfunction

	// One-based position of the lowest set bit, zero for an all-zero word.
	function automatic logic [RankW-1:0] lowest_set64(input logic [MapW-1:0] w);
		logic [RankW-1:0] p;
		p = '0;
		for (int i = MapW - 1; i >= 0; i--) begin
			if (w[i]) begin
				p = RankW'(i + 1);
			end
		end
		return p;
	endfunction

endpackage

[rtl/core/hbb_state.sv]
module hbb_state import hbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rank_load,
	input  logic [5:0]       rank_load_val,
	input  logic [5:0]       swap_threshold,
	input  logic             upd_en,
	input  logic [5:0]       bucket_index,
	input  logic [MapW-1:0]  hash_high,
	output hbb_upd_t         upd
);

	logic [RankW-1:0] rank_q;
	logic [MapW-1:0]  cur_map_q;
	logic [MapW-1:0]  next_map_q;

	logic [RankW-1:0] item_rank;
	logic [MapW-1:0]  bucket_bit;
	logic             hit_cur;
	logic             hit_next;
	logic [MapW-1:0]  cur_set;
	logic [MapW-1:0]  next_set;
	logic [FillW-1:0] pop_cur;
	logic [FillW-1:0] pop_next;
	logic             swap;
	logic [RankW-1:0] rank_new;

	always_comb begin
		item_rank  = lowest_set64(hash_high);
		bucket_bit = MapW'(1) << bucket_index;
		hit_cur    = item_rank > rank_q;
		hit_next   = {1'b0, item_rank} > ({1'b0, rank_q} + 8'd1);
		cur_set    = hit_cur ? (cur_map_q | bucket_bit) : cur_map_q;
		next_set   = hit_next ? (next_map_q | bucket_bit) : next_map_q;
		pop_cur    = popcount64(cur_set);
		pop_next   = popcount64(next_set);
		swap       = pop_cur > {1'b0, swap_threshold};
		rank_new   = (swap && rank_q < RankMax) ? rank_q + 7'd1 : rank_q;
		upd.rank   = rank_new;
		upd.fill   = swap ? pop_next : pop_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q     <= {1'b0, InitRankReset};
			cur_map_q  <= '0;
			next_map_q <= '0;
		end else if (rank_load) begin
			rank_q     <= {1'b0, rank_load_val};
			cur_map_q  <= '0;
			next_map_q <= '0;
		end else if (upd_en) begin
			rank_q     <= rank_new;
			cur_map_q  <= swap ? next_set : cur_set;
			next_map_q <= swap ? '0 : next_set;
		end
	end

	a_rank_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q <= RankMax)
		else $error("rank went above its ceiling");

	a_swap_clears_next: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_en && !rank_load && swap) |=> next_map_q == '0)
		else $error("next bitmap not cleared after a swap");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		rank_load |=> (cur_map_q == '0 && next_map_q == '0 &&
			rank_q == {1'b0, $past(rank_load_val)}))
		else $error("sketch did not restart on initial rank write");

endmodule

[rtl/core/hyperbitbit_cardinality_sketch.sv]
// HyperBitBit cardinality sketch.
//
// The slave stream takes one already hashed key per request: a 6-bit bucket
// index and the 64-bit high hash word. The master stream returns exactly one
// result per request: the current rank, the fill count of the current bitmap,
// the log2 estimate in 1/32 units and the integer cardinality estimate.
// A request is held in an input register, the sketch state (rank and two
// bitmaps) is updated from it and the estimate is formed in a second stage
// before the output register, which drives m_tvalid. One request is taken
// every cycle for as long as the receiver keeps up. When the receiver
// stalls, the output register holds its result and the stages behind it
// fill; s_tready falls only once all three are occupied. The configuration
// port writes the initial rank (which also restarts the sketch), the swap
// threshold and the estimate bias; the user must see that it is used only
// while idle, as the block does not enforce this. Reset loads the register
// defaults (rank 5, threshold 31, bias 173), empties both bitmaps and drops
// every valid flag.
module hyperbitbit_cardinality_sketch import hbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // bucket_index[5:0], hash_high[69:6], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // rank_now[6:0], fill_count[13:7],
	                               // log2_estimate[25:14], estimate[89:26], zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	// Configuration registers.
	logic [5:0] thresh_q;
	logic [9:0] bias_q;
	logic       rank_load;

	// Input stage.
	logic            valid_s1;
	logic [5:0]      bucket_s1;
	logic [MapW-1:0] hash_s1;

	// Sketch result stage.
	logic             valid_s2;
	logic [RankW-1:0] rank_s2;
	logic [FillW-1:0] fill_s2;

	// Output register.
	logic             out_valid_q;
	logic [RankW-1:0] rank_q;
	logic [FillW-1:0] fill_q;
	logic [Log2W-1:0] log2_q;
	logic [EstW-1:0]  est_q;

	logic             out_ready;
	logic             adv_s2;
	logic             upd_en;
	hbb_upd_t         upd;
	logic [Log2W-1:0] log2_val;
	logic [6:0]       log2_int;
	logic [16:0]      pow_frac;
	logic [79:0]      pow_shifted;
	logic [EstW-1:0]  est_val;

	assign out_ready = !out_valid_q || m_tready;
	assign adv_s2    = !valid_s2 || out_ready;
	assign s_tready  = !valid_s1 || adv_s2;
	assign upd_en    = valid_s1 && adv_s2;

	// Only the initial rank write touches the sketch state.
	always_comb begin
		rank_load = 1'b0;
		unique case (cfg_index)
			RegInitialRank: rank_load = cfg_we;
			RegSwapThreshold, RegBias: rank_load = 1'b0;
			default: rank_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
			bias_q   <= BiasReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegInitialRank: ;
				RegSwapThreshold: thresh_q <= cfg_data[5:0];
				RegBias: bias_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			bucket_s1 <= s_tdata[5:0];
			hash_s1   <= s_tdata[69:6];
		end
	end

	hbb_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.rank_load      (rank_load),
		.rank_load_val  (cfg_data[5:0]),
		.swap_threshold (thresh_q),
		.upd_en         (upd_en),
		.bucket_index   (bucket_s1),
		.hash_high      (hash_s1),
		.upd            (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			rank_s2 <= upd.rank;
			fill_s2 <= upd.fill;
		end
	end

	// The log2 sum peaks at 1023 + 32 * 64 + 64, so it always fits 12 bits.
	// Its top seven bits are the power of two and the low five pick the
	// fractional factor. Shifting the 17-bit fraction table entry left by
	// the power and dropping 16 bits covers both the right and left shift
	// cases; powers of 64 and above saturate.
	always_comb begin
		log2_val    = Log2W'(bias_q) + {rank_s2, 5'b0} + Log2W'(fill_s2);
		log2_int    = log2_val[11:5];
		pow_frac    = PowTable[log2_val[4:0]];
		pow_shifted = 80'(pow_frac) << log2_int[5:0];
		est_val     = log2_int[6] ? '1 : pow_shifted[79:FracW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			rank_q <= rank_s2;
			fill_q <= fill_s2;
			log2_q <= log2_val;
			est_q  <= est_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, est_q, log2_q, fill_q, rank_q};

	a_log2_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (log2_q <= 12'd3135 && rank_q <= RankMax && fill_q <= 7'd64))
		else $error("result fields out of range");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(hash_s1) && $stable(bucket_s1)))
		else $error("input stage lost a request while stalled");

	a_stall_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while the receiver stalled");

endmodule

[tb/hbb_sketch_checker.sv]
// Watches both streams and the register port, keeps its own copy of the
// sketch state and compares every result with the oldest prediction.
module hbb_sketch_checker
	import hbb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [RankW-1:0] rank;
		logic [FillW-1:0] fill;
		logic [Log2W-1:0] log2_est;
		logic [EstW-1:0]  est;
	} sketch_result_t;

	// 2^(f/32) scaled by 2^16 and rounded.
	localparam logic [16:0] Exp2Frac [32] = '{
		17'd65536,  17'd66971,  17'd68438,  17'd69936,
		17'd71468,  17'd73032,  17'd74632,  17'd76266,
		17'd77936,  17'd79642,  17'd81386,  17'd83169,
		17'd84990,  17'd86851,  17'd88752,  17'd90696,
		17'd92682,  17'd94711,  17'd96785,  17'd98905,
		17'd101070, 17'd103283, 17'd105545, 17'd107856,
		17'd110218, 17'd112631, 17'd115098, 17'd117618,
		17'd120194, 17'd122825, 17'd125515, 17'd128263
	};

	logic [5:0]       thresh_q;
	logic [9:0]       bias_q;
	logic [RankW-1:0] rank_q;
	logic [MapW-1:0]  cur_map_q;
	logic [MapW-1:0]  nxt_map_q;
	sketch_result_t   predicted_results [$];

	function automatic logic [RankW-1:0] first_one_pos(input logic [63:0] w);
		for (int i = 0; i < 64; i++) begin
			if (w[i]) begin
				return RankW'(i + 1);
			end
		end
		return '0;
	endfunction

	function automatic logic [FillW-1:0] ones_in(input logic [63:0] w);
		int n = 0;
		for (int i = 0; i < 64; i++) begin
			n += int'(w[i]);
		end
		return FillW'(n);
	endfunction

	function automatic logic [EstW-1:0] exp2_from_log(input logic [Log2W-1:0] l);
		int          q;
		logic [63:0] t;
		q = int'(l >> 5);
		t = 64'(Exp2Frac[l[4:0]]);
		if (q < 16) begin
			return t >> (16 - q);
		end
		if (q >= 64) begin
			return '1;
		end
		return t << (q - 16);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		fail_count++;
		$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
			$time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		sketch_result_t   want;
		sketch_result_t   got;
		logic [RankW-1:0] key_rank;
		logic [FillW-1:0] fill;
		int               l;
		if (!arst_n) begin
			thresh_q    = ThreshReset;
			bias_q      = BiasReset;
			rank_q      = RankW'(InitRankReset);
			cur_map_q   = '0;
			nxt_map_q   = '0;
			predicted_results.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.rank     = m_tdata[6:0];
				got.fill     = m_tdata[13:7];
				got.log2_est = m_tdata[25:14];
				got.est      = m_tdata[89:26];
				if (predicted_results.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with no request waiting, expected none, %s",
						$time, $sformatf("actual rank %0d fill %0d", got.rank, got.fill));
				end else begin
					want = predicted_results.pop_front();
					if (got.rank !== want.rank) begin
						flag_mismatch("rank_now", 64'(want.rank), 64'(got.rank));
					end
					if (got.fill !== want.fill) begin
						flag_mismatch("fill_count", 64'(want.fill), 64'(got.fill));
					end
					if (got.log2_est !== want.log2_est) begin
						flag_mismatch("log2_estimate", 64'(want.log2_est), 64'(got.log2_est));
					end
					if (got.est !== want.est) begin
						flag_mismatch("estimate", want.est, got.est);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					RegInitialRank: begin
						rank_q      = RankW'(cfg_data[5:0]);
						cur_map_q   = '0;
						nxt_map_q   = '0;
					end
					RegSwapThreshold: begin
						thresh_q = cfg_data[5:0];
					end
					RegBias: begin
						bias_q = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				key_rank = first_one_pos(s_tdata[69:6]);
				if (key_rank > rank_q) begin
					cur_map_q[s_tdata[5:0]] = 1'b1;
				end
				if (int'(key_rank) > int'(rank_q) + 1) begin
					nxt_map_q[s_tdata[5:0]] = 1'b1;
				end
				if (ones_in(cur_map_q) > thresh_q) begin
					if (rank_q < RankMax) begin
						rank_q++;
					end
					cur_map_q = nxt_map_q;
					nxt_map_q = '0;
				end
				fill = ones_in(cur_map_q);
				l = int'(bias_q) + 32 * int'(rank_q) + int'(fill);
				if (l > 4095) begin
					l = 4095;
				end
				want.rank     = rank_q;
				want.fill     = fill;
				want.log2_est = Log2W'(l);
				want.est      = exp2_from_log(Log2W'(l));
				predicted_results.push_back(want);
			end
			outstanding = predicted_results.size();
		end
	end

endmodule

[tb/tb_hyperbitbit_cardinality_sketch.sv]
// Top of the sketch testbench. It makes the clock and the reset, drives the
// request stream, the result stream's ready and the register port, and gives
// the verdict. All prediction and comparison lives in the checker beside the
// block, which hands back a failure count and the number of results still due.
module tb_hyperbitbit_cardinality_sketch;
	timeunit 1ns;
	timeprecision 1ps;
	import hbb_pkg::*;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [1:0] RegNone = 2'd3;
	// Length of the one long receiver hold-off, in cycles.
	localparam int LongHoldCycles = 300;
	localparam int Phases = 10;
	localparam int KeysPerPhase = 110;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = RegInitialRank;
	logic [9:0]  cfg_data = '0;

	int fail_count;
	int outstanding;
	// Idling chances in percent, changed between phases by the stimulus.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// The stimulus asks for a long hold-off by raising holds_asked; the
	// receiver process serves it and counts the cycles itself.
	int holds_asked = 0;
	int holds_served = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	hyperbitbit_cardinality_sketch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hbb_sketch_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Receiver side. Ready changes only at the falling edge. During a long
	// hold-off it stays low, so the block's three stages fill up and its
	// input ready drops while the sender keeps offering requests.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_served != holds_asked) begin
				hold_left = LongHoldCycles;
				holds_served++;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offers one request, starting at a falling edge, and returns at the
	// falling edge after it was accepted. Valid is only ever lowered for a
	// gap, so it is never dropped and raised again within one time step.
	task automatic offer_key(input logic [5:0] bucket, input logic [63:0] hash);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= {2'b00, hash, bucket};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stops offering and waits until every predicted result has come back,
	// so that the block is idle and a register may be written.
	task automatic settle_results();
		s_tvalid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	// One register write, then the enable is lowered again before the task
	// returns, so that back-to-back writes never assign the enable twice in one step.
	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// A hash word whose lowest set bit sits at one-based position r, with
	// random bits above it; rank zero gives the all-zero word.
	function automatic logic [63:0] hash_of_rank(input int r);
		logic [63:0] h;
		if (r == 0) begin
			return '0;
		end
		h = {$urandom(), $urandom()} << r;
		h[r-1] = 1'b1;
		return h;
	endfunction

	// Plain random hashes follow the natural rank distribution, which rarely
	// beats a high current rank; a uniform rank keeps the sketch advancing.
	function automatic logic [63:0] random_hash();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			return {$urandom(), $urandom()};
		end else if (pick < 90) begin
			return hash_of_rank($urandom_range(64));
		end else if (pick < 94) begin
			return '0;
		end else if (pick < 97) begin
			return '1;
		end
		return 64'h8000_0000_0000_0000;
	endfunction

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset settings (rank 5, threshold 31).
		// A zero hash has rank zero and sets nothing; all ones has rank one.
		offer_key(6'd0, 64'd0);
		offer_key(6'd63, '1);
		// Top bit alone is the highest rank: sets the bit in both bitmaps.
		offer_key(6'd0, 64'h8000_0000_0000_0000);
		// Rank six sets only the current bitmap, rank seven both.
		offer_key(6'd63, hash_of_rank(6));
		offer_key(6'd1, hash_of_rank(7));
		offer_key(6'd2, hash_of_rank(5));
		settle_results();

		// Threshold zero: the next request swaps the bitmaps and advances.
		write_reg(RegSwapThreshold, 10'd0);
		offer_key(6'd5, hash_of_rank(3));
		offer_key(6'd6, hash_of_rank(64));
		offer_key(6'd7, hash_of_rank(9));
		settle_results();

		// Rank near its ceiling with the largest bias: the rank saturates at
		// 64 and the integer estimate saturates at all ones.
		write_reg(RegInitialRank, 10'd63);
		write_reg(RegBias, 10'h3FF);
		offer_key(6'd33, hash_of_rank(64));
		offer_key(6'd34, hash_of_rank(64));
		offer_key(6'd35, '1);
		settle_results();

		// Smallest rank, bias and widest threshold: the estimate shifts right.
		write_reg(RegInitialRank, 10'd0);
		write_reg(RegBias, 10'd0);
		write_reg(RegSwapThreshold, 10'd63);
		offer_key(6'd10, 64'd0);
		offer_key(6'd11, hash_of_rank(1));
		offer_key(6'd12, hash_of_rank(2));
		offer_key(6'd63, hash_of_rank(40));
		settle_results();

		// A write to an index without a register must leave everything alone.
		write_reg(RegNone, 10'h3FF);
		offer_key(6'd20, hash_of_rank(2));
		offer_key(6'd21, hash_of_rank(1));

		// Random phases, each with its own settings and idling pattern.
		for (int p = 0; p < Phases; p++) begin
			settle_results();
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct  = 25;
					recv_stall_pct = 25;
				end
			endcase
			case (p)
				0: begin
					write_reg(RegSwapThreshold, 10'd31);
					write_reg(RegBias, 10'd173);
					write_reg(RegInitialRank, 10'd5);
				end
				1: begin
					write_reg(RegSwapThreshold, 10'd0);
					write_reg(RegInitialRank, 10'd0);
				end
				2: begin
					write_reg(RegSwapThreshold, 10'd63);
					write_reg(RegBias, 10'd1023);
				end
				3: begin
					write_reg(RegInitialRank, 10'd63);
					write_reg(RegSwapThreshold, 10'd1);
				end
				4: begin
					write_reg(RegBias, 10'd0);
					write_reg(RegInitialRank, 10'd0);
					write_reg(RegSwapThreshold, 10'd7);
				end
				default: begin
					// Sometimes keep the state from the phase before, so the
					// rank can climb far over many requests.
					if ($urandom_range(1) == 1) begin
						write_reg(RegInitialRank, 10'($urandom_range(63)));
					end
					write_reg(RegSwapThreshold, 10'($urandom_range(40)));
					write_reg(RegBias, 10'($urandom_range(1023)));
				end
			endcase
			if (p == 5) begin
				holds_asked++;
			end
			repeat (KeysPerPhase) begin
				offer_key(6'($urandom_range(63)), random_hash());
			end
		end

		settle_results();
		// Keep watching after the results have settled so that any stray result is still caught.
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// A correct run ends long before this limit, even with the heaviest
	// idling and the long hold-off.
	initial begin : watchdog
		#2_400_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[hyperbitbit_cardinality_sketch.f]
rtl/core/hbb_pkg.sv
rtl/core/hbb_state.sv
rtl/core/hyperbitbit_cardinality_sketch.sv
tb/hbb_sketch_checker.sv
tb/tb_hyperbitbit_cardinality_sketch.sv
